FILE: hw/rtl/ssb_pkg.sv
// ----------------------------------------------------------------------------
// ssb_pkg
// Shared constants of the spectral subtraction bin processor: parameter
// defaults, register reset values, register indexes and fixed-point widths.
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int NUM_BINS_DEF  = 256;
  localparam int BIN_WIDTH_DEF = 24;

  // Configuration port.
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_EST_FRAMES = 2'd0;
  localparam logic [1:0] REG_SUB_GAIN   = 2'd1;
  localparam logic [1:0] REG_FLOOR_GAIN = 2'd2;

  localparam int EST_W   = 8;
  localparam int SGAIN_W = 12;
  localparam int FGAIN_W = 10;

  localparam logic [EST_W-1:0]   EST_FRAMES_RST = 8'd50;
  localparam logic [SGAIN_W-1:0] SUB_GAIN_RST   = 12'd1229;
  localparam logic [FGAIN_W-1:0] FLOOR_GAIN_RST = 10'd20;

  // Fixed point: gains are Q.10.
  localparam int FRAC_W = 10;

  // Noise store entries and the profile divider.
  localparam int STORE_W      = 32;
  localparam int DIV_BITS     = 2;
  localparam int DIV_STEPS    = STORE_W / DIV_BITS;

endpackage

FILE: hw/rtl/ssb_stream_if.sv
// ----------------------------------------------------------------------------
// ssb_stream_if
// Valid/ready stream interfaces for spectrum bins in and cleaned bins out.
// ----------------------------------------------------------------------------
interface ssb_in_if #(
  parameter int BW = ssb_pkg::BIN_WIDTH_DEF
) ();
  logic          valid;
  logic          ready;
  logic [BW-1:0] bin_real;
  logic [BW-1:0] bin_imag;
  logic          suppress_on;

  modport source (output valid, bin_real, bin_imag, suppress_on, input ready);
  modport sink   (input valid, bin_real, bin_imag, suppress_on, output ready);
endinterface

interface ssb_out_if #(
  parameter int BW = ssb_pkg::BIN_WIDTH_DEF
) ();
  logic          valid;
  logic          ready;
  logic [BW-1:0] out_real;
  logic [BW-1:0] out_imag;
  logic [7:0]    bin_number;
  logic          frame_end;
  logic          estimating;

  modport source (output valid, out_real, out_imag, bin_number, frame_end, estimating,
                  input ready);
  modport sink   (input valid, out_real, out_imag, bin_number, frame_end, estimating,
                  output ready);
endinterface

FILE: hw/rtl/spectral_subtraction_bins.sv
// ----------------------------------------------------------------------------
// spectral_subtraction_bins
// Per-bin spectral subtraction: magnitude, noise profile estimation over the
// first frames of the stream, and scaling of each bin by clean/magnitude.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  bin_i     in         bin_real, bin_imag, suppress_on (one bin per transaction)
//  res_o     out        out_real, out_imag, bin_number, frame_end, estimating
//  APB       in/out     estimation_frames @0x0, subtract_gain @0x4, floor_gain @0x8
//
//  One bin is accepted per clock cycle unless the pipeline stalls. On its way
//  to the output register a bin passes the pipelined square root, the
//  two-bits-per-stage profile divider, the scaling divider and ten further
//  register stages. Reset is asynchronous and needs no clearing pass: the
//  first estimation frame treats the noise store as zero. The whole pipeline
//  stalls only when its last stage holds a result and the output register is
//  full and not being drained; bubbles keep moving.
//
module spectral_subtraction_bins #(
  parameter int NUM_BINS  = ssb_pkg::NUM_BINS_DEF,
  parameter int BIN_WIDTH = ssb_pkg::BIN_WIDTH_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ssb_in_if.sink                     bin_i,
  ssb_out_if.source                  res_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ssb_pkg::ADDR_W-1:0] paddr,
  input  logic [ssb_pkg::DATA_W-1:0] pwdata,
  output logic [ssb_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int BW    = BIN_WIDTH;
  localparam int KW    = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int RADW  = 2 * BW;
  localparam int SW_   = ssb_pkg::STORE_W;
  localparam int FW    = ssb_pkg::FRAC_W;
  localparam int PW    = BW + SW_;
  localparam int CW    = 46;
  localparam int SUBW  = ssb_pkg::SGAIN_W + SW_;
  localparam int FLOW  = ssb_pkg::FGAIN_W + SW_;
  localparam int DSTEP = ssb_pkg::DIV_STEPS;
  localparam int DBITS = ssb_pkg::DIV_BITS;

  // Stage map.
  localparam int ST_SQ  = 1;
  localparam int ST_RAD = 2;
  localparam int ST_RT0 = 3;
  localparam int ST_MAG = ST_RT0 + BW - 1;
  localparam int ST_RD  = ST_MAG + 1;
  localparam int ST_ACC = ST_RD + 1;
  localparam int ST_NZ  = ST_ACC + DSTEP;
  localparam int ST_PR  = ST_NZ + 1;
  localparam int ST_CL  = ST_PR + 1;
  localparam int ST_PP  = ST_CL + 1;
  localparam int ST_OV  = ST_PP + 1;
  localparam int ST_QE  = ST_OV + BW;
  localparam int NST    = ST_QE + 1;

  localparam logic [KW-1:0] LAST_BIN = KW'(NUM_BINS - 1);
  localparam logic [BW-1:0] POS_MAX  = {1'b0, {(BW-1){1'b1}}};
  localparam logic [BW-1:0] NEG_MIN  = {1'b1, {(BW-1){1'b0}}};

  typedef struct packed {
    logic [BW-1:0] re;
    logic [BW-1:0] im;
    logic [BW-1:0] are;
    logic [BW-1:0] aim;
    logic [KW-1:0] k;
    logic          last;
    logic          est;
    logic          use_noise;
    logic          zero_rd;
    logic [7:0]    div;
  } meta_t;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes complete in the APB access phase.
  // ---------------------------------------------------------------------------
  logic [ssb_pkg::EST_W-1:0]   est_frames_q;
  logic [ssb_pkg::SGAIN_W-1:0] sub_gain_q;
  logic [ssb_pkg::FGAIN_W-1:0] floor_gain_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_frames_q <= ssb_pkg::EST_FRAMES_RST;
      sub_gain_q   <= ssb_pkg::SUB_GAIN_RST;
      floor_gain_q <= ssb_pkg::FLOOR_GAIN_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        ssb_pkg::REG_EST_FRAMES: est_frames_q <= pwdata[ssb_pkg::EST_W-1:0];
        ssb_pkg::REG_SUB_GAIN:   sub_gain_q   <= pwdata[ssb_pkg::SGAIN_W-1:0];
        ssb_pkg::REG_FLOOR_GAIN: floor_gain_q <= pwdata[ssb_pkg::FGAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      ssb_pkg::REG_EST_FRAMES: prdata = 32'(est_frames_q);
      ssb_pkg::REG_SUB_GAIN:   prdata = 32'(sub_gain_q);
      ssb_pkg::REG_FLOOR_GAIN: prdata = 32'(floor_gain_q);
      default:                 prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Flow control. All stages advance together; a bubble in the last stage
  // lets the pipeline move even while the output register is held.
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_q;
  logic           out_valid_q;
  logic           adv;
  logic           take;
  logic           out_load;

  assign adv         = !v_q[NST-1] || !out_valid_q || res_o.ready;
  assign bin_i.ready = adv;
  assign take        = bin_i.valid && adv;
  assign out_load    = !out_valid_q || res_o.ready;

  // ---------------------------------------------------------------------------
  // Frame tracking. Whether a frame closes the estimation, and its divisor,
  // are decided at bin 0.
  // ---------------------------------------------------------------------------
  logic [KW-1:0] bin_q;
  logic [7:0]    frames_q;
  logic          ready_q;
  logic          final_q;
  logic [7:0]    pdiv_q;

  logic [7:0]    n_div;
  logic          first_bin;
  logic          ff0;
  logic          ff;
  meta_t         meta_in;

  always_comb begin
    n_div     = (est_frames_q == '0) ? 8'd1 : est_frames_q;
    first_bin = (bin_q == '0);
    ff0       = !ready_q && (({1'b0, frames_q} + 9'd1) >= {1'b0, n_div});
    ff        = first_bin ? ff0 : final_q;

    meta_in.re        = bin_i.bin_real;
    meta_in.im        = bin_i.bin_imag;
    meta_in.are       = bin_i.bin_real[BW-1] ? (~bin_i.bin_real + 1'b1) : bin_i.bin_real;
    meta_in.aim       = bin_i.bin_imag[BW-1] ? (~bin_i.bin_imag + 1'b1) : bin_i.bin_imag;
    meta_in.k         = bin_q;
    meta_in.last      = (bin_q == LAST_BIN);
    meta_in.est       = !ready_q;
    meta_in.use_noise = (ready_q || ff) && bin_i.suppress_on;
    meta_in.zero_rd   = (frames_q == '0);
    meta_in.div       = (first_bin && ff0) ? n_div : pdiv_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_q    <= '0;
      frames_q <= '0;
      ready_q  <= 1'b0;
      final_q  <= 1'b0;
      pdiv_q   <= 8'd1;
    end else if (take) begin
      if (meta_in.last) begin
        bin_q   <= '0;
        final_q <= 1'b0;
        if (!ready_q) begin
          if (frames_q != 8'hFF) begin
            frames_q <= frames_q + 8'd1;
          end
          if (ff) begin
            ready_q <= 1'b1;
          end
        end
      end else begin
        bin_q <= bin_q + 1'b1;
        if (first_bin) begin
          final_q <= ff0;
          if (ff0) begin
            pdiv_q <= n_div;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits and the per-item side information that travels with the data.
  // ---------------------------------------------------------------------------
  meta_t meta_q [NST];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[NST-2:0], bin_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta_q[0] <= meta_in;
      for (int i = 1; i < NST; i++) begin
        meta_q[i] <= meta_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Squares and their sum.
  // ---------------------------------------------------------------------------
  logic [RADW-1:0] sqre_q;
  logic [RADW-1:0] sqim_q;
  logic [RADW-1:0] rad_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqre_q <= meta_q[0].are * meta_q[0].are;
      sqim_q <= meta_q[0].aim * meta_q[0].aim;
      rad_q  <= sqre_q + sqim_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Integer square root, one root bit per stage, most significant first.
  // The remainder holds radicand minus root squared.
  // ---------------------------------------------------------------------------
  logic [RADW-1:0] rem_q  [ST_RT0:ST_MAG];
  logic [BW-1:0]   root_q [ST_RT0:ST_MAG];

  for (genvar j = 0; j < BW; j++) begin : g_rt
    localparam int I = BW - 1 - j;
    logic [RADW-1:0] rin;
    logic [BW-1:0]   qin;
    logic [RADW-1:0] trial;

    if (j == 0) begin : g_first
      assign rin = rad_q;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_q[ST_RT0+j-1];
      assign qin = root_q[ST_RT0+j-1];
    end

    assign trial = (RADW'(qin) << (I + 1)) | (RADW'(1) << (2 * I));

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rin >= trial) begin
          rem_q[ST_RT0+j]  <= rin - trial;
          root_q[ST_RT0+j] <= qin | (BW'(1) << I);
        end else begin
          rem_q[ST_RT0+j]  <= rin;
          root_q[ST_RT0+j] <= qin;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Noise store. Read as the item leaves the root stage, updated one stage
  // later; two bins with the same index are never closer than two stages.
  // Estimation frames keep the running sum, saturated; the division by the
  // frame count is done on every read path instead.
  // ---------------------------------------------------------------------------
  logic [SW_-1:0] store_q [NUM_BINS];
  logic [SW_-1:0] rdata_q;
  logic [BW-1:0]  mag_q [ST_RD:NST-1];
  logic [SW_-1:0] base;
  logic [SW_:0]   sum_w;
  logic [SW_-1:0] sum_sat;

  always_comb begin
    base    = meta_q[ST_RD].zero_rd ? '0 : rdata_q;
    sum_w   = {1'b0, base} + (SW_+1)'(mag_q[ST_RD]);
    sum_sat = sum_w[SW_] ? '1 : sum_w[SW_-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rdata_q <= store_q[meta_q[ST_MAG].k];
      if (v_q[ST_RD] && meta_q[ST_RD].est) begin
        store_q[meta_q[ST_RD].k] <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mag_q[ST_RD] <= root_q[ST_MAG];
      for (int i = ST_RD + 1; i < NST; i++) begin
        mag_q[i] <= mag_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Profile divider: noise = stored sum / frame count, two quotient bits per
  // stage. The quotient shifts into the dividend register from the right.
  // ---------------------------------------------------------------------------
  logic [7:0]     drem_q [ST_ACC:ST_NZ];
  logic [SW_-1:0] dnum_q [ST_ACC:ST_NZ];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      drem_q[ST_ACC] <= '0;
      dnum_q[ST_ACC] <= meta_q[ST_RD].est ? sum_sat : rdata_q;
    end
  end

  for (genvar s = 0; s < DSTEP; s++) begin : g_dv
    logic [7:0]     r;
    logic [SW_-1:0] n;
    logic [8:0]     r9;

    always_comb begin
      r  = drem_q[ST_ACC+s];
      n  = dnum_q[ST_ACC+s];
      r9 = '0;
      for (int b = 0; b < DBITS; b++) begin
        r9 = {r, n[SW_-1]};
        n  = {n[SW_-2:0], 1'b0};
        if (r9 >= {1'b0, meta_q[ST_ACC+s].div}) begin
          r9   = r9 - {1'b0, meta_q[ST_ACC+s].div};
          n[0] = 1'b1;
        end
        r = r9[7:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        drem_q[ST_ACC+s+1] <= r;
        dnum_q[ST_ACC+s+1] <= n;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Clean magnitude: max(mag - subtract_gain*noise, floor_gain*noise), Q.10.
  // ---------------------------------------------------------------------------
  logic [SUBW-1:0] psub_q;
  logic [FLOW-1:0] pflo_q;
  logic [SW_-1:0]  clean_q [ST_CL:NST-1];
  logic signed [CW-1:0] sub_c;
  logic signed [CW-1:0] flo_c;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      psub_q <= sub_gain_q * dnum_q[ST_NZ];
      pflo_q <= floor_gain_q * dnum_q[ST_NZ];
    end
  end

  always_comb begin
    sub_c = $signed({{(CW-BW-FW){1'b0}}, mag_q[ST_PR], {FW{1'b0}}})
          - $signed({{(CW-SUBW){1'b0}}, psub_q});
    flo_c = $signed({{(CW-FLOW){1'b0}}, pflo_q});
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      clean_q[ST_CL] <= (sub_c > flo_c) ? sub_c[FW +: SW_] : flo_c[FW +: SW_];
      for (int i = ST_CL + 1; i < NST; i++) begin
        clean_q[i] <= clean_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Scaling: |part| * clean / mag. An overflow flag marks quotients that
  // cannot fit BW bits; below it the quotient is found one bit per stage.
  // ---------------------------------------------------------------------------
  logic [PW-1:0] pre_q;
  logic [PW-1:0] pim_q;
  logic          ovr_q [ST_OV:NST-1];
  logic          ovi_q [ST_OV:NST-1];
  logic [PW-1:0] rre_q [ST_OV:ST_QE];
  logic [PW-1:0] rim_q [ST_OV:ST_QE];
  logic [BW-1:0] qre_q [ST_OV:ST_QE];
  logic [BW-1:0] qim_q [ST_OV:ST_QE];
  logic [PW-1:0] lim_c;

  assign lim_c = PW'(mag_q[ST_PP]) << BW;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      pre_q <= meta_q[ST_CL].are * clean_q[ST_CL];
      pim_q <= meta_q[ST_CL].aim * clean_q[ST_CL];

      ovr_q[ST_OV] <= (pre_q >= lim_c);
      ovi_q[ST_OV] <= (pim_q >= lim_c);
      rre_q[ST_OV] <= pre_q;
      rim_q[ST_OV] <= pim_q;
      qre_q[ST_OV] <= '0;
      qim_q[ST_OV] <= '0;
      for (int i = ST_OV + 1; i < NST; i++) begin
        ovr_q[i] <= ovr_q[i-1];
        ovi_q[i] <= ovi_q[i-1];
      end
    end
  end

  for (genvar j = 0; j < BW; j++) begin : g_qt
    localparam int I = BW - 1 - j;
    logic [PW-1:0] t;

    assign t = PW'(mag_q[ST_OV+j]) << I;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        if (rre_q[ST_OV+j] >= t) begin
          rre_q[ST_OV+j+1] <= rre_q[ST_OV+j] - t;
          qre_q[ST_OV+j+1] <= qre_q[ST_OV+j] | (BW'(1) << I);
        end else begin
          rre_q[ST_OV+j+1] <= rre_q[ST_OV+j];
          qre_q[ST_OV+j+1] <= qre_q[ST_OV+j];
        end
        if (rim_q[ST_OV+j] >= t) begin
          rim_q[ST_OV+j+1] <= rim_q[ST_OV+j] - t;
          qim_q[ST_OV+j+1] <= qim_q[ST_OV+j] | (BW'(1) << I);
        end else begin
          rim_q[ST_OV+j+1] <= rim_q[ST_OV+j];
          qim_q[ST_OV+j+1] <= qim_q[ST_OV+j];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result selection and saturation into the output register.
  // ---------------------------------------------------------------------------
  function automatic logic [BW-1:0] sat_part(input logic neg, input logic ovf,
                                             input logic [BW-1:0] q);
    logic [BW-1:0] res;
    if (ovf || q[BW-1]) begin
      res = neg ? NEG_MIN : POS_MAX;
    end else begin
      res = neg ? (~q + 1'b1) : q;
    end
    return res;
  endfunction

  meta_t          m_l;
  logic [BW-1:0]  ore_d;
  logic [BW-1:0]  oim_d;
  logic [KW+7:0]  kx;

  always_comb begin
    m_l = meta_q[NST-1];
    kx  = {8'd0, m_l.k};
    if (!m_l.use_noise) begin
      ore_d = m_l.re;
      oim_d = m_l.im;
    end else if (mag_q[NST-1] == '0) begin
      // Silent bin: the floor term alone sets the real part.
      ore_d = (clean_q[NST-1] > SW_'(POS_MAX)) ? POS_MAX : clean_q[NST-1][BW-1:0];
      oim_d = '0;
    end else begin
      ore_d = sat_part(m_l.re[BW-1], ovr_q[NST-1], qre_q[ST_QE]);
      oim_d = sat_part(m_l.im[BW-1], ovi_q[NST-1], qim_q[ST_QE]);
    end
  end

  logic [BW-1:0] out_re_q;
  logic [BW-1:0] out_im_q;
  logic [7:0]    out_bin_q;
  logic          out_end_q;
  logic          out_est_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= v_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_re_q  <= ore_d;
      out_im_q  <= oim_d;
      out_bin_q <= kx[7:0];
      out_end_q <= m_l.last;
      out_est_q <= m_l.est;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.out_real   = out_re_q;
  assign res_o.out_imag   = out_im_q;
  assign res_o.bin_number = out_bin_q;
  assign res_o.frame_end  = out_end_q;
  assign res_o.estimating = out_est_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_take_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> v_q[0])
    else $error("accepted bin did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipeline moved during a stall");

  a_ready_frames : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> (frames_q != 8'd0))
    else $error("noise profile ready before any frame was seen");

  a_bin_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bin_q <= LAST_BIN)
    else $error("bin counter out of range");

endmodule

FILE: dv/tb_spectral_subtraction_bins.sv
// ----------------------------------------------------------------------------
// tb_spectral_subtraction_bins
// Self-checking testbench for the spectral subtraction bin processor. Bins are
// streamed through valid/ready channels with random gaps and back-pressure.
// Each accepted bin is run through a behavioural predictor of the magnitude,
// the noise profile and the subtraction, and every result is compared with it.
// ----------------------------------------------------------------------------
module tb_spectral_subtraction_bins;
  timeunit 1ns;
  timeprecision 1ps;
  import ssb_pkg::*;

  localparam int BW       = BIN_WIDTH_DEF;
  localparam int NBINS    = NUM_BINS_DEF;
  // The drain wait covers the pipeline at the default width with margin.
  localparam int DRAIN    = 120;
  localparam int WDOG_MAX = 20000;

  typedef logic signed [BW-1:0] part_t;

  typedef struct packed {
    logic [BW-1:0] out_real;
    logic [BW-1:0] out_imag;
    logic [7:0]    bin_number;
    logic          frame_end;
    logic          estimating;
  } clean_bin_t;

  // One row of the directed table: a bin, and optionally its result typed in.
  typedef struct {
    part_t re;
    part_t im;
    logic  sup;
    bit    typed;
    part_t exp_re;
    part_t exp_im;
  } bin_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ADDR_W-1:0]   paddr   = '0;
  logic [DATA_W-1:0]   pwdata  = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  ssb_in_if  #(.BW(BW)) bin_if ();
  ssb_out_if #(.BW(BW)) res_if ();

  spectral_subtraction_bins #(
    .NUM_BINS (NBINS),
    .BIN_WIDTH(BW)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .bin_i  (bin_if),
    .res_o  (res_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: the noise profile and the frame bookkeeping.
  logic [31:0] noise_prof [NBINS];
  int unsigned frames_cnt;
  bit          prof_ready;
  int unsigned bin_idx;
  bit          last_est_frame;
  int unsigned prof_div;
  // Register copies held by the predictor.
  logic [EST_W-1:0]   cfg_frames;
  logic [SGAIN_W-1:0] cfg_sgain;
  logic [FGAIN_W-1:0] cfg_fgain;

  clean_bin_t expected_bins[$];

  int unsigned n_bins_sent;
  int unsigned n_bins_checked;
  int unsigned n_supp_checked;
  int unsigned n_errors;
  bit          gaps_off;
  bit          stalls_off;
  bit          stall_req;
  bit          sup_frame;

  // Floor integer square root, one result bit per pass from the top.
  function automatic longint unsigned mag_root(longint unsigned x);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic part_t clip_part(longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (BW - 1)) - 1;
    lo = -(longint'(1) <<< (BW - 1));
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return part_t'(v);
  endfunction

  function automatic longint scaled_part(longint p, longint unsigned clean,
                                         longint unsigned mag);
    longint unsigned q;
    q = ((p < 0 ? -p : p) * clean) / mag;
    return p < 0 ? -longint'(q) : longint'(q);
  endfunction

  // Works out the result of one accepted bin and advances the predictor state.
  task automatic predict_clean_bin(input part_t re, input part_t im, input logic sup,
                                   output clean_bin_t res);
    longint          sre;
    longint          sim;
    longint unsigned mag;
    longint unsigned sum;
    longint unsigned noise;
    longint          sub;
    longint          flo;
    longint unsigned clean;
    int unsigned     n;
    bit              est;
    sre = longint'(re);
    sim = longint'(im);
    if (bin_idx == 0) begin
      n = (cfg_frames == 0) ? 1 : cfg_frames;
      last_est_frame = !prof_ready && (frames_cnt + 1 >= n);
      prof_div = n;
    end
    mag = mag_root(longint'(sre * sre) + longint'(sim * sim));
    est = !prof_ready;
    if (est) begin
      sum = longint'(noise_prof[bin_idx]) + mag;
      if (sum > 64'hFFFF_FFFF) sum = 64'hFFFF_FFFF;
      if (last_est_frame) sum = sum / prof_div;
      noise_prof[bin_idx] = sum[31:0];
    end
    res.out_real = re;
    res.out_imag = im;
    if ((prof_ready || last_est_frame) && sup) begin
      noise = noise_prof[bin_idx];
      sub   = longint'(mag << FRAC_W) - longint'(cfg_sgain * noise);
      flo   = longint'(cfg_fgain * noise);
      clean = longint'(sub > flo ? sub : flo) >> FRAC_W;
      if (mag == 0) begin
        // A silent bin carries the floor as a real value.
        res.out_real = clip_part(longint'(clean));
        res.out_imag = '0;
      end else begin
        res.out_real = clip_part(scaled_part(sre, clean, mag));
        res.out_imag = clip_part(scaled_part(sim, clean, mag));
      end
      n_supp_checked++;
    end
    res.bin_number = bin_idx[7:0];
    res.frame_end  = (bin_idx == NBINS - 1);
    res.estimating = est;
    if (bin_idx == NBINS - 1) begin
      bin_idx = 0;
      if (!prof_ready) begin
        if (frames_cnt < 255) frames_cnt++;
        if (last_est_frame) prof_ready = 1'b1;
      end
      last_est_frame = 1'b0;
    end else begin
      bin_idx++;
    end
  endtask

  // Offers one bin, waits for the transaction and records what it should give.
  task automatic send_bin(input bin_row_t row);
    clean_bin_t res;
    if (!gaps_off && $urandom_range(99) < 33) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk_i);
        bin_if.valid <= 1'b0;
      end
    end
    @(negedge clk_i);
    bin_if.valid       <= 1'b1;
    bin_if.bin_real    <= row.re;
    bin_if.bin_imag    <= row.im;
    bin_if.suppress_on <= row.sup;
    do @(posedge clk_i); while (!bin_if.ready);
    predict_clean_bin(row.re, row.im, row.sup, res);
    if (row.typed) begin
      // Typed rows override the data fields with the value read off by hand.
      res.out_real = row.exp_re;
      res.out_imag = row.exp_im;
    end
    expected_bins.push_back(res);
    n_bins_sent++;
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [DATA_W-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_EST_FRAMES: cfg_frames = val[EST_W-1:0];
      REG_SUB_GAIN:   cfg_sgain  = val[SGAIN_W-1:0];
      REG_FLOOR_GAIN: cfg_fgain  = val[FGAIN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apb_check(input logic [1:0] idx, input logic [DATA_W-1:0] want);
    logic [DATA_W-1:0] got;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== want) begin
      $error("register %0d: expected %0d, got %0d", idx, want, got);
      n_errors++;
    end
  endtask

  // Lets the pipeline empty out before a register is touched.
  task automatic drain_pipeline();
    @(negedge clk_i);
    bin_if.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  // Random part value: small or mid-range half the time so that magnitudes sit
  // near the noise profile, with full-range and extreme values making up the rest.
  function automatic part_t rand_part();
    case ($urandom_range(3))
      0: return part_t'($signed($urandom_range(127)) - 64);
      1: return part_t'($signed($urandom_range(8191)) - 4096);
      2: return part_t'($urandom);
      default: begin
        case ($urandom_range(4))
          0: return {1'b0, {(BW-1){1'b1}}};
          1: return {1'b1, {(BW-1){1'b0}}};
          2: return '0;
          3: return '1;
          default: return part_t'(1);
        endcase
      end
    endcase
  endfunction

  // Random bins; suppression is chosen per frame and now and then flipped.
  task automatic send_random(input int unsigned count);
    bin_row_t row;
    for (int unsigned i = 0; i < count; i++) begin
      if (bin_idx == 0) sup_frame = ($urandom_range(99) < 80);
      row.re    = rand_part();
      row.im    = rand_part();
      row.sup   = ($urandom_range(99) < 3) ? !sup_frame : sup_frame;
      row.typed = 1'b0;
      send_bin(row);
    end
  endtask

  // Result side: random ready, plus one long hold-off asked for by the stimulus.
  int unsigned hold_left;
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (stall_req) begin
        hold_left = 400;
        stall_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= stalls_off ? 1'b1 : ($urandom_range(99) >= 33);
      end
    end
  end

  // Each result transaction is compared with the oldest expectation.
  always @(posedge clk_i) begin
    clean_bin_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_bins.size() == 0) begin
        $error("result transaction with no bin outstanding");
        n_errors++;
      end else begin
        want = expected_bins.pop_front();
        n_bins_checked++;
        if (res_if.out_real !== want.out_real) begin
          $error("out_real: expected %0d, got %0d",
                 $signed(want.out_real), $signed(res_if.out_real));
          n_errors++;
        end
        if (res_if.out_imag !== want.out_imag) begin
          $error("out_imag: expected %0d, got %0d",
                 $signed(want.out_imag), $signed(res_if.out_imag));
          n_errors++;
        end
        if (res_if.bin_number !== want.bin_number) begin
          $error("bin_number: expected %0d, got %0d", want.bin_number, res_if.bin_number);
          n_errors++;
        end
        if (res_if.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, res_if.frame_end);
          n_errors++;
        end
        if (res_if.estimating !== want.estimating) begin
          $error("estimating: expected %0d, got %0d", want.estimating, res_if.estimating);
          n_errors++;
        end
      end
    end
  end

  // Watchdog: too long without any transaction on any port ends the run.
  int unsigned quiet_cycles;
  always @(posedge clk_i) begin
    if ((bin_if.valid && bin_if.ready) || (res_if.valid && res_if.ready) ||
        (psel && penable) || !rst_ni) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("watchdog expired with %0d results outstanding", expected_bins.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  bin_row_t dir_rows[$];

  initial begin
    bin_row_t row;
    bin_if.valid       = 1'b0;
    bin_if.bin_real    = '0;
    bin_if.bin_imag    = '0;
    bin_if.suppress_on = 1'b0;
    res_if.ready       = 1'b0;
    for (int k = 0; k < NBINS; k++) noise_prof[k] = '0;
    frames_cnt     = 0;
    prof_ready     = 1'b0;
    bin_idx        = 0;
    last_est_frame = 1'b0;
    prof_div       = 1;
    cfg_frames     = EST_FRAMES_RST;
    cfg_sgain      = SUB_GAIN_RST;
    cfg_fgain      = FLOOR_GAIN_RST;
    n_bins_sent    = 0;
    n_bins_checked = 0;
    n_supp_checked = 0;
    n_errors       = 0;
    gaps_off       = 1'b0;
    stalls_off     = 1'b0;
    stall_req      = 1'b0;
    sup_frame      = 1'b1;
    hold_left      = 0;
    quiet_cycles   = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // The registers come out of reset with their documented defaults.
    apb_check(REG_EST_FRAMES, DATA_W'(EST_FRAMES_RST));
    apb_check(REG_SUB_GAIN,   DATA_W'(SUB_GAIN_RST));
    apb_check(REG_FLOOR_GAIN, DATA_W'(FLOOR_GAIN_RST));

    // A profile over two frames keeps the estimation phase short. The
    // highest count is written and read back first; it is latched only at
    // the first bin, so the final value of two is the one that counts.
    apb_write(REG_EST_FRAMES, 32'd255);
    apb_check(REG_EST_FRAMES, 32'd255);
    apb_write(REG_EST_FRAMES, 32'd2);

    // Directed bins in the first estimation frame: every bin passes through
    // untouched, whether suppression is asked for or not.
    row.typed = 1'b1;
    foreach (row.re[i]) ;
    for (int r = 0; r < 20; r++) begin
      case (r % 10)
        0: begin row.re = {1'b0, {(BW-1){1'b1}}}; row.im = {1'b0, {(BW-1){1'b1}}}; end
        1: begin row.re = {1'b1, {(BW-1){1'b0}}}; row.im = {1'b1, {(BW-1){1'b0}}}; end
        2: begin row.re = '0;                      row.im = '0;                      end
        3: begin row.re = {1'b1, {(BW-1){1'b0}}}; row.im = '0;                      end
        4: begin row.re = '0;                      row.im = {1'b1, {(BW-1){1'b0}}}; end
        5: begin row.re = {1'b0, {(BW-1){1'b1}}}; row.im = {1'b1, {(BW-1){1'b0}}}; end
        6: begin row.re = '1;                      row.im = part_t'(1);             end
        7: begin row.re = part_t'(3000);           row.im = part_t'(-4000);         end
        8: begin row.re = part_t'(-1);             row.im = '1;                      end
        default: begin row.re = part_t'(12345);    row.im = part_t'(-54321);        end
      endcase
      row.sup    = r[0];
      row.exp_re = row.re;
      row.exp_im = row.im;
      dir_rows.push_back(row);
    end
    foreach (dir_rows[i]) send_bin(dir_rows[i]);

    // Rest of the two estimation frames and the start of suppression at the
    // reset gains; the final estimation frame already applies the profile.
    send_random(2 * NBINS - dir_rows.size() + 60);

    // No subtraction and no floor: suppressed bins come out unchanged.
    drain_pipeline();
    apb_write(REG_SUB_GAIN,   32'd0);
    apb_write(REG_FLOOR_GAIN, 32'd0);
    send_random(300);

    // Strongest subtraction and highest floor; the frame count now has no
    // effect since the profile is fixed, but the lowest value is exercised.
    drain_pipeline();
    apb_write(REG_SUB_GAIN,   32'd4095);
    apb_write(REG_FLOOR_GAIN, 32'd1023);
    apb_write(REG_EST_FRAMES, 32'd1);
    send_random(250);

    // Random gains, with the result side held off for a long stretch while
    // bins keep coming without gaps, so the pipeline fills and stalls.
    drain_pipeline();
    apb_write(REG_SUB_GAIN,   DATA_W'($urandom_range(4095)));
    apb_write(REG_FLOOR_GAIN, DATA_W'($urandom_range(1023)));
    gaps_off  = 1'b1;
    stall_req = 1'b1;
    send_random(450);
    gaps_off  = 1'b0;

    // Back to the reset gains, with a stretch where neither side idles.
    drain_pipeline();
    apb_write(REG_SUB_GAIN,   DATA_W'(SUB_GAIN_RST));
    apb_write(REG_FLOOR_GAIN, DATA_W'(FLOOR_GAIN_RST));
    stalls_off = 1'b1;
    gaps_off   = 1'b1;
    send_random(200);
    stalls_off = 1'b0;
    gaps_off   = 1'b0;
    send_random(200);

    @(negedge clk_i);
    bin_if.valid <= 1'b0;
    while (expected_bins.size() != 0) @(posedge clk_i);
    // Anything arriving now is an extra result and is flagged by the checker.
    repeat (DRAIN) @(posedge clk_i);

    $display("Run covered %0d bins over %0d frames, %0d of them suppressed,", n_bins_sent,
             (n_bins_sent + NBINS - 1) / NBINS, n_supp_checked);
    $display("with four gain settings, a long output stall and %0d results checked.",
             n_bins_checked);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
